// File: hdl/kam_pkg.sv
// kam_pkg: shared types and constants for the keyed adjacency matrix table
// request kinds, status codes, field widths and the sequencer state type
// no dependencies
package kam_pkg;

  localparam int KEY_W    = 15;
  localparam int WEIGHT_W = 15;
  localparam int DEG_W    = 19;

  localparam logic [DEG_W-1:0]    DEG_MAX    = 19'h7ffff;
  localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = 15'h7fff;

  // request kinds
  localparam logic [2:0] K_ADD = 3'd0;
  localparam logic [2:0] K_DEL = 3'd1;
  localparam logic [2:0] K_SET = 3'd2;
  localparam logic [2:0] K_GET = 3'd3;
  localparam logic [2:0] K_DEG = 3'd4;
  localparam logic [2:0] K_ACC = 3'd5;

  // status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_KEY    = 3'd1;
  localparam logic [2:0] ST_NO_NODE    = 3'd2;
  localparam logic [2:0] ST_BAD_WEIGHT = 3'd3;
  localparam logic [2:0] ST_FULL       = 3'd4;

  // accumulate phases
  localparam logic [1:0] PH_KEY_A = 2'd0;
  localparam logic [1:0] PH_KEY_B = 2'd1;
  localparam logic [1:0] PH_EDGE  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_DECIDE,
    S_CLR,
    S_WR_NODE,
    S_ADD_DONE,
    S_RD_W,
    S_USE_W,
    S_RD_DEG,
    S_USE_DEG,
    S_SUM_RD,
    S_SUM_ACC,
    S_SUM_WR,
    S_RESP
  } state_t;

endpackage

// File: hdl/kam_ram.sv
// kam_ram: single-port memory with registered read data
// one write or read address per cycle; no dependencies
module kam_ram #(
  parameter int WIDTH = 15,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: hdl/keyed_adjacency_matrix_table.sv
// keyed_adjacency_matrix_table: node slot table with weighted adjacency matrix
// uses kam_pkg and kam_ram; one request at a time
// lookup scans the key memory one used slot at a time
// add reuses a dead slot or appends with a row/column clear; accumulate runs up to 3 scans
// delete: scan, row/column clear, then a re-sum of every used row over the one-port matrix memory
// rst (synchronous) clears live marks, slot count and handshake; no clearing pass
module keyed_adjacency_matrix_table
  import kam_pkg::*;
#(
  parameter int MAX_NODES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // key_a[15:0], key_b[31:16], weight[47:32]
  input  logic [2:0]  s_tuser,   // kind[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // status[2:0], value[21:3], slot_count[26:22], zero
);

  localparam int IDXW = $clog2(MAX_NODES);
  localparam int CNTW = $clog2(MAX_NODES + 1);
  localparam int EAW  = 2 * IDXW;
  localparam int ACCW = WEIGHT_W + CNTW;

  state_t state, state_next;

  // captured request
  logic [2:0]  kind, kind_next;
  logic [15:0] ka, ka_next;
  logic [15:0] kb, kb_next;
  logic [15:0] wt, wt_next;
  logic [1:0]  phase, phase_next;

  // scan keys and results
  logic [15:0]     sk_a, sk_a_next;
  logic [15:0]     sk_b, sk_b_next;
  logic [IDXW-1:0] idx, idx_next;
  logic            fa, fa_next, fb, fb_next, df, df_next;
  logic [IDXW-1:0] sa, sa_next, sb, sb_next, ds, ds_next;

  // clear and re-sum control
  logic [IDXW-1:0] slot, slot_next;
  logic [IDXW-1:0] clr_lim, clr_lim_next;
  logic            clr_ph, clr_ph_next;
  logic            clr_app, clr_app_next;
  logic [IDXW-1:0] si, si_next, sj, sj_next;
  logic [ACCW-1:0] acc, acc_next;

  // table state
  logic [CNTW-1:0]      used, used_next;
  logic [MAX_NODES-1:0] live, live_next;

  // result
  logic [2:0]       status, status_next;
  logic [DEG_W-1:0] value, value_next;
  logic             m_tvalid_next;
  logic [31:0]      m_tdata_next;

  // memory ports
  logic                key_we;
  logic [IDXW-1:0]     key_addr;
  logic [KEY_W-1:0]    key_wd, key_rd;
  logic                deg_we;
  logic [IDXW-1:0]     deg_addr;
  logic [DEG_W-1:0]    deg_wd, deg_rd;
  logic                e_we;
  logic [EAW-1:0]      e_addr;
  logic [WEIGHT_W-1:0] e_wd, e_rd;

  logic               scan_last, si_last, sj_last;
  logic               match_a, match_b;
  logic               add_mode;
  logic signed [16:0] acc_sum;
  logic [DEG_W-1:0]   deg_sat;

  kam_ram #(.WIDTH(KEY_W), .AW(IDXW)) u_key_ram (
    .clk(clk), .we(key_we), .addr(key_addr), .wdata(key_wd), .rdata(key_rd)
  );

  kam_ram #(.WIDTH(DEG_W), .AW(IDXW)) u_deg_ram (
    .clk(clk), .we(deg_we), .addr(deg_addr), .wdata(deg_wd), .rdata(deg_rd)
  );

  // matrix addressed {row, col}
  kam_ram #(.WIDTH(WEIGHT_W), .AW(EAW)) u_edge_ram (
    .clk(clk), .we(e_we), .addr(e_addr), .wdata(e_wd), .rdata(e_rd)
  );

  assign s_tready = (state == S_IDLE);

  // shared compare/add helpers
  assign scan_last = ((CNTW'(idx) + 1'b1) == used);
  assign si_last   = ((CNTW'(si) + 1'b1) == used);
  assign sj_last   = ((CNTW'(sj) + 1'b1) == used);
  // negative keys never match a slot
  assign match_a   = live[idx] && !sk_a[15] && (key_rd == sk_a[KEY_W-1:0]);
  assign match_b   = live[idx] && !sk_b[15] && (key_rd == sk_b[KEY_W-1:0]);
  assign add_mode  = (kind == K_ADD) || ((kind == K_ACC) && (phase != PH_EDGE));
  assign acc_sum   = $signed({2'b00, e_rd}) + 17'(signed'(wt));
  assign deg_sat   = (32'(acc) > 32'(DEG_MAX)) ? DEG_MAX : DEG_W'(acc);

  always_comb begin
    state_next    = state;
    kind_next     = kind;
    ka_next       = ka;
    kb_next       = kb;
    wt_next       = wt;
    phase_next    = phase;
    sk_a_next     = sk_a;
    sk_b_next     = sk_b;
    idx_next      = idx;
    fa_next       = fa;
    fb_next       = fb;
    df_next       = df;
    sa_next       = sa;
    sb_next       = sb;
    ds_next       = ds;
    slot_next     = slot;
    clr_lim_next  = clr_lim;
    clr_ph_next   = clr_ph;
    clr_app_next  = clr_app;
    si_next       = si;
    sj_next       = sj;
    acc_next      = acc;
    used_next     = used;
    live_next     = live;
    status_next   = status;
    value_next    = value;
    m_tdata_next  = m_tdata;
    m_tvalid_next = m_tvalid && !m_tready;

    key_we   = 1'b0;
    key_addr = idx;
    key_wd   = sk_a[KEY_W-1:0];
    deg_we   = 1'b0;
    deg_addr = sa;
    deg_wd   = '0;
    e_we     = 1'b0;
    e_addr   = {sa, sb};
    e_wd     = '0;

    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          kind_next   = s_tuser;
          ka_next     = s_tdata[15:0];
          kb_next     = s_tdata[31:16];
          wt_next     = s_tdata[47:32];
          sk_a_next   = s_tdata[15:0];
          sk_b_next   = s_tdata[31:16];
          phase_next  = PH_KEY_A;
          status_next = ST_OK;
          value_next  = '0;
          idx_next    = '0;
          fa_next     = 1'b0;
          fb_next     = 1'b0;
          df_next     = 1'b0;
          case (s_tuser) inside
            K_ADD, K_ACC: begin
              if (s_tdata[15]) begin
                status_next = ST_BAD_KEY;
                state_next  = S_RESP;
              end else begin
                state_next = (used == '0) ? S_DECIDE : S_SCAN_RD;
              end
            end
            K_SET: begin
              // weight sign checked before any lookup
              if (s_tdata[47]) begin
                status_next = ST_BAD_WEIGHT;
                state_next  = S_RESP;
              end else begin
                state_next = (used == '0) ? S_DECIDE : S_SCAN_RD;
              end
            end
            K_DEL, K_GET, K_DEG: begin
              state_next = (used == '0) ? S_DECIDE : S_SCAN_RD;
            end
            default: begin
              state_next = S_RESP;
            end
          endcase
        end
      end

      S_SCAN_RD: begin
        state_next = S_SCAN_CMP;
      end

      S_SCAN_CMP: begin
        if (match_a && !fa) begin
          fa_next = 1'b1;
          sa_next = idx;
        end
        if (match_b && !fb) begin
          fb_next = 1'b1;
          sb_next = idx;
        end
        if (!live[idx] && !df) begin
          df_next = 1'b1;
          ds_next = idx;
        end
        if (scan_last) begin
          state_next = S_DECIDE;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = S_SCAN_RD;
        end
      end

      S_DECIDE: begin
        if (add_mode) begin
          if (fa) begin
            state_next = S_ADD_DONE;
          end else if (df) begin
            slot_next  = ds;
            state_next = S_WR_NODE;
          end else if (used == CNTW'(MAX_NODES)) begin
            status_next = ST_FULL;
            state_next  = S_RESP;
          end else begin
            // append: clear the new row and column first
            slot_next    = IDXW'(used);
            clr_lim_next = IDXW'(used);
            used_next    = used + 1'b1;
            idx_next     = '0;
            clr_ph_next  = 1'b0;
            clr_app_next = 1'b1;
            state_next   = S_CLR;
          end
        end else begin
          case (kind)
            K_DEL: begin
              if (!fa) begin
                status_next = ST_NO_NODE;
                state_next  = S_RESP;
              end else begin
                live_next[sa] = 1'b0;
                slot_next     = sa;
                clr_lim_next  = IDXW'(used - 1'b1);
                idx_next      = '0;
                clr_ph_next   = 1'b0;
                clr_app_next  = 1'b0;
                state_next    = S_CLR;
              end
            end
            K_SET: begin
              if (!(fa && fb)) begin
                status_next = ST_NO_NODE;
              end else begin
                e_we = 1'b1;
                e_wd = wt[WEIGHT_W-1:0];
              end
              state_next = S_RESP;
            end
            K_GET, K_ACC: begin
              if (!(fa && fb)) begin
                status_next = ST_NO_NODE;
                state_next  = S_RESP;
              end else begin
                state_next = S_RD_W;
              end
            end
            K_DEG: begin
              if (!fa) begin
                status_next = ST_NO_NODE;
                state_next  = S_RESP;
              end else begin
                state_next = S_RD_DEG;
              end
            end
            default: begin
              state_next = S_RESP;
            end
          endcase
        end
      end

      S_CLR: begin
        // row entry, then column entry, for each index
        e_we        = 1'b1;
        e_addr      = clr_ph ? {idx, slot} : {slot, idx};
        clr_ph_next = !clr_ph;
        if (clr_ph) begin
          if (idx == clr_lim) begin
            if (clr_app) begin
              state_next = S_WR_NODE;
            end else begin
              si_next    = '0;
              sj_next    = '0;
              acc_next   = '0;
              state_next = S_SUM_RD;
            end
          end else begin
            idx_next = idx + 1'b1;
          end
        end
      end

      S_WR_NODE: begin
        key_we          = 1'b1;
        key_addr        = slot;
        deg_we          = 1'b1;
        deg_addr        = slot;
        live_next[slot] = 1'b1;
        state_next      = S_ADD_DONE;
      end

      S_ADD_DONE: begin
        idx_next = '0;
        fa_next  = 1'b0;
        fb_next  = 1'b0;
        df_next  = 1'b0;
        if (kind != K_ACC) begin
          state_next = S_RESP;
        end else if (phase == PH_KEY_A) begin
          phase_next = PH_KEY_B;
          sk_a_next  = kb;
          if (kb[15]) begin
            status_next = ST_BAD_KEY;
            state_next  = S_RESP;
          end else begin
            state_next = S_SCAN_RD;
          end
        end else begin
          phase_next = PH_EDGE;
          sk_a_next  = ka;
          sk_b_next  = kb;
          state_next = S_SCAN_RD;
        end
      end

      S_RD_W: begin
        state_next = S_USE_W;
      end

      S_USE_W: begin
        if (kind == K_GET) begin
          value_next = DEG_W'(e_rd);
        end else if (acc_sum[16]) begin
          status_next = ST_BAD_WEIGHT;
        end else begin
          e_we = 1'b1;
          e_wd = (acc_sum[16:15] != 2'b00) ? WEIGHT_MAX : acc_sum[WEIGHT_W-1:0];
        end
        state_next = S_RESP;
      end

      S_RD_DEG: begin
        state_next = S_USE_DEG;
      end

      S_USE_DEG: begin
        value_next = deg_rd;
        state_next = S_RESP;
      end

      S_SUM_RD: begin
        e_addr     = {si, sj};
        state_next = S_SUM_ACC;
      end

      S_SUM_ACC: begin
        acc_next = acc + ACCW'(e_rd);
        if (sj_last) begin
          state_next = S_SUM_WR;
        end else begin
          sj_next    = sj + 1'b1;
          state_next = S_SUM_RD;
        end
      end

      S_SUM_WR: begin
        deg_we   = 1'b1;
        deg_addr = si;
        deg_wd   = deg_sat;
        acc_next = '0;
        sj_next  = '0;
        if (si_last) begin
          state_next = S_RESP;
        end else begin
          si_next    = si + 1'b1;
          state_next = S_SUM_RD;
        end
      end

      S_RESP: begin
        // hold until the output register is free
        if (!m_tvalid || m_tready) begin
          m_tvalid_next = 1'b1;
          m_tdata_next  = {5'b00000, 5'(used), value, status};
          state_next    = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      used     <= '0;
      live     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      used     <= used_next;
      live     <= live_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  always_ff @(posedge clk) begin
    kind    <= kind_next;
    ka      <= ka_next;
    kb      <= kb_next;
    wt      <= wt_next;
    phase   <= phase_next;
    sk_a    <= sk_a_next;
    sk_b    <= sk_b_next;
    idx     <= idx_next;
    fa      <= fa_next;
    fb      <= fb_next;
    df      <= df_next;
    sa      <= sa_next;
    sb      <= sb_next;
    ds      <= ds_next;
    slot    <= slot_next;
    clr_lim <= clr_lim_next;
    clr_ph  <= clr_ph_next;
    clr_app <= clr_app_next;
    si      <= si_next;
    sj      <= sj_next;
    acc     <= acc_next;
    status  <= status_next;
    value   <= value_next;
    m_tdata <= m_tdata_next;
  end

endmodule

// File: hdl/kam_checker.sv
// kam_checker: port-level assertions for keyed_adjacency_matrix_table
// uses kam_pkg; bound to the top level below
module kam_checker
  import kam_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  // stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output beat changed while stalled");

  // one request at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while request in flight");

  // only defined status codes
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[2:0] == ST_OK) || (m_tdata[2:0] == ST_BAD_KEY) ||
                 (m_tdata[2:0] == ST_NO_NODE) || (m_tdata[2:0] == ST_BAD_WEIGHT) ||
                 (m_tdata[2:0] == ST_FULL))
    else $error("undefined status code");

  // failed requests read no value
  a_err_value: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[2:0] != ST_OK) |-> (m_tdata[21:3] == '0))
    else $error("value nonzero on error status");

endmodule

bind keyed_adjacency_matrix_table kam_checker u_kam_checker (.*);

// File: tb/tb.sv
// tb: self-checking bench for keyed_adjacency_matrix_table
// drives directed rows, a fill to full, then random traffic; checks every response
// against typed rows or the in-bench table model; depends on kam_pkg and the rtl top
module tb;
  import kam_pkg::*;

  localparam int NODES = 16;
  localparam int RANDOM_REQS = 1200;

  typedef struct packed {
    logic [2:0]  status;
    logic [18:0] value;
    logic [4:0]  slots;
  } resp_t;

  typedef struct {
    logic [2:0]  kind;
    logic [15:0] ka;
    logic [15:0] kb;
    logic [15:0] w;
    bit          fixed;  // expected response typed in below
    resp_t       resp;
  } req_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [31:0] m_tdata;

  keyed_adjacency_matrix_table #(.MAX_NODES(NODES)) DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // bench copy of the table
  logic [KEY_W-1:0]    node_key [NODES];
  bit                  node_live [NODES];
  logic [DEG_W-1:0]    node_deg [NODES];
  int                  slots_used;
  logic [WEIGHT_W-1:0] adj [NODES][NODES];

  resp_t pending_resp[$];
  int    errors = 0;
  bit    stim_done = 0;

  function automatic int find_node(logic signed [15:0] key);
    if (key < 0) return -1;
    for (int i = 0; i < slots_used; i++)
      if (node_live[i] && node_key[i] == key[14:0]) return i;
    return -1;
  endfunction

  function automatic logic [2:0] add_node(logic signed [15:0] key);
    int s;
    if (key < 0) return ST_BAD_KEY;
    if (find_node(key) >= 0) return ST_OK;
    s = -1;
    for (int i = 0; i < slots_used; i++)
      if (!node_live[i] && s < 0) s = i;
    if (s < 0) begin
      if (slots_used >= NODES) return ST_FULL;
      s = slots_used;
      slots_used++;
      for (int i = 0; i < NODES; i++) begin
        adj[s][i] = '0;
        adj[i][s] = '0;
      end
    end
    node_key[s] = key[14:0];
    node_live[s] = 1;
    node_deg[s] = '0;
    return ST_OK;
  endfunction

  function automatic logic [2:0] delete_node(logic signed [15:0] key);
    int s;
    int sum;
    s = find_node(key);
    if (s < 0) return ST_NO_NODE;
    node_live[s] = 0;
    for (int i = 0; i < slots_used; i++) begin
      adj[s][i] = '0;
      adj[i][s] = '0;
    end
    // every used slot takes its row sum, clipped to the degree width
    for (int i = 0; i < slots_used; i++) begin
      sum = 0;
      for (int j = 0; j < slots_used; j++) sum += adj[i][j];
      node_deg[i] = sum > DEG_MAX ? DEG_MAX : sum[DEG_W-1:0];
    end
    return ST_OK;
  endfunction

  function automatic resp_t predict_table(req_t r);
    resp_t o;
    int sa, sb, sum;
    logic signed [15:0] w;
    w = r.w;
    o.status = ST_OK;
    o.value = '0;
    case (r.kind)
      K_ADD: o.status = add_node(r.ka);
      K_DEL: o.status = delete_node(r.ka);
      K_SET: begin
        if (w < 0) o.status = ST_BAD_WEIGHT;
        else begin
          sa = find_node(r.ka);
          sb = find_node(r.kb);
          if (sa < 0 || sb < 0) o.status = ST_NO_NODE;
          else adj[sa][sb] = w[14:0];
        end
      end
      K_GET: begin
        sa = find_node(r.ka);
        sb = find_node(r.kb);
        if (sa < 0 || sb < 0) o.status = ST_NO_NODE;
        else o.value = adj[sa][sb];
      end
      K_DEG: begin
        sa = find_node(r.ka);
        if (sa < 0) o.status = ST_NO_NODE;
        else o.value = node_deg[sa];
      end
      K_ACC: begin
        o.status = add_node(r.ka);
        if (o.status == ST_OK) o.status = add_node(r.kb);
        if (o.status == ST_OK) begin
          sa = find_node(r.ka);
          sb = find_node(r.kb);
          if (sa < 0 || sb < 0) o.status = ST_NO_NODE;
          else begin
            sum = int'(adj[sa][sb]) + int'(w);
            if (sum < 0) o.status = ST_BAD_WEIGHT;
            else adj[sa][sb] = sum > 32767 ? WEIGHT_MAX : sum[14:0];
          end
        end
      end
      default: ;  // undefined kinds answer ok and change nothing
    endcase
    o.slots = slots_used[4:0];
    return o;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  // keys drawn from a small pool so lookups hit, with occasional wild values
  function automatic logic [15:0] pick_key();
    case ($urandom_range(0, 19))
      0: return 16'($urandom_range(32768, 65535));
      1: return 16'($urandom_range(0, 32767));
      2: return 16'h7fff;
      default: return 16'($urandom_range(0, 23));
    endcase
  endfunction

  function automatic logic [15:0] pick_weight();
    case ($urandom_range(0, 9))
      0: return 16'($urandom_range(32768, 65535));
      1: return 16'h7fff;
      2: return 16'($urandom_range(0, 32767));
      3: return 16'hffff - 16'($urandom_range(0, 50));
      default: return 16'($urandom_range(0, 3000));
    endcase
  endfunction

  task automatic send_req(req_t r);
    resp_t e;
    int g;
    e = predict_table(r);
    if (r.fixed && e !== r.resp)
      $display("%0t: table row disagrees with model: exp %h model %h", $time, r.resp, e);
    if (r.fixed) e = r.resp;
    pending_resp.push_back(e);
    s_tdata <= {r.w, r.kb, r.ka};
    s_tuser <= r.kind;
    s_tvalid <= 1;
    do @(posedge clk); while (!s_tready);
    // with no gap the next beat follows at once, valid stays high
    g = gap_len();
    if (g > 0) begin
      s_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
  endtask

  function automatic req_t mk(logic [2:0] k, logic [15:0] a, logic [15:0] b,
                              logic [15:0] w, bit f = 0, logic [2:0] st = ST_OK,
                              logic [18:0] v = '0, logic [4:0] n = '0);
    req_t r;
    r.kind = k; r.ka = a; r.kb = b; r.w = w;
    r.fixed = f; r.resp = '{st, v, n};
    return r;
  endfunction

  // directed rows: reset state, extremes, every kind, error codes
  req_t directed[$];
  initial begin
    directed = '{
      mk(K_DEG, 16'd5, 0, 0, 1, ST_NO_NODE, 0, 0),         // empty table
      mk(K_ADD, 16'h8000, 0, 0, 1, ST_BAD_KEY, 0, 0),      // negative key
      mk(K_ADD, 16'd0, 0, 0, 1, ST_OK, 0, 1),
      mk(K_ADD, 16'h7fff, 0, 0, 1, ST_OK, 0, 2),
      mk(K_ADD, 16'd0, 0, 0, 1, ST_OK, 0, 2),              // duplicate is a no-op
      mk(K_SET, 16'd0, 16'h7fff, 16'hffff, 1, ST_BAD_WEIGHT, 0, 2),
      mk(K_SET, 16'd0, 16'h7fff, 16'h7fff, 1, ST_OK, 0, 2),
      mk(K_GET, 16'd0, 16'h7fff, 0, 1, ST_OK, 19'h7fff, 2),
      mk(K_GET, 16'd0, 16'hffff, 0, 1, ST_NO_NODE, 0, 2),
      mk(K_ACC, 16'd0, 16'h7fff, 16'd5, 1, ST_OK, 0, 2),   // saturates
      mk(K_ACC, 16'd7, 16'd0, 16'h8000, 1, ST_BAD_WEIGHT, 0, 3),
      mk(K_ACC, 16'd9, 16'h8001, 16'd1, 1, ST_BAD_KEY, 0, 4),
      mk(K_SET, 16'h7fff, 16'd0, 16'd100, 0),
      mk(K_SET, 16'h7fff, 16'h7fff, 16'd200, 0),
      mk(K_DEL, 16'd0, 0, 0, 1, ST_OK, 0, 4),
      mk(K_DEG, 16'h7fff, 0, 0, 1, ST_OK, 19'd200, 4),
      mk(K_DEL, 16'd0, 0, 0, 1, ST_NO_NODE, 0, 4),
      mk(K_ADD, 16'd3, 0, 0, 1, ST_OK, 0, 4),              // reuses a dead slot
      mk(K_DEG, 16'd3, 0, 0, 1, ST_OK, 0, 4),
      mk(3'd6, 16'hffff, 16'hffff, 16'hffff, 1, ST_OK, 0, 4),
      mk(3'd7, 16'h5555, 16'haaaa, 16'h5555, 1, ST_OK, 0, 4)
    };
  end

  // request side
  initial begin
    req_t r;
    slots_used = 0;
    for (int i = 0; i < NODES; i++) begin
      node_live[i] = 0; node_deg[i] = '0; node_key[i] = '0;
      for (int j = 0; j < NODES; j++) adj[i][j] = '0;
    end
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    foreach (directed[i]) send_req(directed[i]);
    // fill to full; the remaining adds overflow
    for (int i = 0; i < 20; i++) send_req(mk(K_ADD, 16'(100 + i), 0, 0));
    for (int n = 0; n < RANDOM_REQS; n++) begin
      r = mk(3'($urandom_range(0, 99) < 3 ? $urandom_range(6, 7) : $urandom_range(0, 5)),
             pick_key(), pick_key(), pick_weight());
      // deletes kept rarer so the table stays populated
      if (r.kind == K_DEL && $urandom_range(0, 2) != 0) r.kind = K_ACC;
      if (r.kind == K_ADD && slots_used == NODES && $urandom_range(0, 1) == 0) r.kind = K_DEL;
      send_req(r);
    end
    s_tvalid <= 0;
    stim_done = 1;
  end

  // response side: random backpressure, check against oldest expectation
  initial begin
    resp_t got, e;
    @(negedge rst);
    forever begin
      if ($urandom_range(0, 30) == 0) begin
        m_tready <= 0;
        repeat ($urandom_range(10, 40)) @(posedge clk);
      end
      m_tready <= ($urandom_range(0, 3) != 0);
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        got = '{m_tdata[2:0], m_tdata[21:3], m_tdata[26:22]};
        if (pending_resp.size() == 0) begin
          $display("%0t: unexpected response %h", $time, got);
          errors++;
        end else begin
          e = pending_resp.pop_front();
          if (got.status !== e.status || got.value !== e.value || got.slots !== e.slots
              || m_tdata[31:27] !== '0) begin
            $display("%0t: mismatch exp status %0d value %0d slots %0d, got %0d %0d %0d",
                     $time, e.status, e.value, e.slots, got.status, got.value, got.slots);
            errors++;
          end
        end
      end
    end
  end

  // end of run: drain, then allow the longest delete to settle
  initial begin
    wait (stim_done);
    wait (pending_resp.size() == 0);
    repeat (1500) @(posedge clk);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #100000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
